/* src/u8d_pkg.sv */
// shared types and constants for the strict utf-8 decoder
`timescale 1ns / 1ps

package u8d_pkg;

  localparam logic [7:0] LEAD_MIN   = 8'hC2;
  localparam logic [7:0] LEAD_MAX   = 8'hF4;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] CONT_MAX   = 8'hBF;
  localparam logic [7:0] LEAD2_MAX  = 8'hDF;
  localparam logic [7:0] LEAD3_MAX  = 8'hEF;
  localparam logic [7:0] LEAD_E0    = 8'hE0;
  localparam logic [7:0] E0_LO      = 8'hA0;
  localparam logic [7:0] LEAD_ED    = 8'hED;
  localparam logic [7:0] ED_HI      = 8'h9F;
  localparam logic [7:0] LEAD_F0    = 8'hF0;
  localparam logic [7:0] F0_LO      = 8'h90;
  localparam logic [7:0] F4_HI      = 8'h8F;

  localparam int CP_W    = 21;
  localparam int CNT_W   = 3;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // one queued job: raw flush of pending bytes, then an optional final result
  typedef struct packed {
    logic [1:0]       flush_n;
    logic [7:0]       lead;
    logic [7:0]       cont0;
    logic [7:0]       cont1;
    logic             fin_v;
    logic [CP_W-1:0]  fin_cp;
    logic [CNT_W-1:0] fin_cnt;
    logic             fin_raw;
  } job_t;

  // queue status seen by the input handshake and the back end
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* src/strict_utf8_decoder_top.sv */
// top level of the strict utf-8 decoder: front, job queue and back end
// a byte with results is queued as a job, then its first word enters the output register
// throughput: one input word per cycle while the 4-entry job queue has room
// output: one result word per cycle while out_tready is high, each job's words in order
// bursts of up to four results drain from the queue while input keeps flowing
// reset: synchronous active-low rst_n clears sequence state, queue pointers and output valid
`timescale 1ns / 1ps

module strict_utf8_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] byte_count
  output logic        out_tuser,  // [0] is_raw
  output logic        out_tlast   // run_last: last result of this input word
);

  logic                       accept;
  logic                       push;
  logic                       pop;
  u8d_pkg::job_t              push_job;
  u8d_pkg::job_t              head_job;
  u8d_pkg::q_stat_t           stat;
  logic [u8d_pkg::CP_W-1:0]   cp;
  logic [u8d_pkg::CNT_W-1:0]  cnt;

  // the front only stalls when the queue is full
  assign in_tready = !stat.full;
  assign accept    = in_tvalid && in_tready;

  // classify the byte and update the pending sequence
  u8d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_tdata),
    .push      (push),
    .job       (push_job)
  );

  // decouples byte intake from result expansion
  u8d_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .stat     (stat)
  );

  // expands each job into raw flush words and the optional final word
  u8d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_job  (head_job),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_cp    (cp),
    .out_cnt   (cnt),
    .out_raw   (out_tuser),
    .out_last  (out_tlast)
  );

  assign out_tdata = {cnt, cp};

endmodule

/* src/u8d_front.sv */
// front end: byte classification, sequence state and job building
`timescale 1ns / 1ps

module u8d_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  output logic               push,
  output u8d_pkg::job_t      job
);

  logic [7:0] lead_r, lead_nxt;
  logic [7:0] cont0_r, cont0_nxt;
  logic [7:0] cont1_r, cont1_nxt;
  logic [1:0] have_r, have_nxt;

  logic       is_cont;
  logic [7:0] lo, hi;
  logic       cont_ok;
  logic [2:0] need;
  logic       complete;
  logic [5:0] c3;
  logic       do_lead;

  always_comb begin
    lo = u8d_pkg::CONT_TAG;
    hi = u8d_pkg::CONT_MAX;
    if (have_r == 2'd1) begin
      if (lead_r == u8d_pkg::LEAD_E0) lo = u8d_pkg::E0_LO;
      if (lead_r == u8d_pkg::LEAD_ED) hi = u8d_pkg::ED_HI;
      if (lead_r == u8d_pkg::LEAD_F0) lo = u8d_pkg::F0_LO;
      if (lead_r == u8d_pkg::LEAD_MAX) hi = u8d_pkg::F4_HI;
    end
    is_cont = (data_byte & u8d_pkg::CONT_MASK) == u8d_pkg::CONT_TAG;
    cont_ok = is_cont && (data_byte >= lo) && (data_byte <= hi);
    if (lead_r <= u8d_pkg::LEAD2_MAX)      need = 3'd2;
    else if (lead_r <= u8d_pkg::LEAD3_MAX) need = 3'd3;
    else                                   need = 3'd4;
    complete = ({1'b0, have_r} + 3'd1) >= need;
    c3 = data_byte[5:0];
  end

  always_comb begin
    lead_nxt  = lead_r;
    cont0_nxt = cont0_r;
    cont1_nxt = cont1_r;
    have_nxt  = have_r;
    do_lead   = 1'b0;
    job         = '0;
    job.lead    = lead_r;
    job.cont0   = cont0_r;
    job.cont1   = cont1_r;
    job.fin_cnt = 3'd1;

    if (data_byte == 8'd0) begin
      // end of text: flush whatever is pending
      job.flush_n = have_r;
      have_nxt    = 2'd0;
    end else if (have_r == 2'd0) begin
      do_lead = 1'b1;
    end else if (cont_ok) begin
      if (complete) begin
        job.fin_v   = 1'b1;
        job.fin_cnt = need;
        unique case (need)
          3'd2:    job.fin_cp = {10'd0, lead_r[4:0], c3};
          3'd3:    job.fin_cp = {5'd0, lead_r[3:0], cont0_r[5:0], c3};
          default: job.fin_cp = {lead_r[2:0], cont0_r[5:0], cont1_r[5:0], c3};
        endcase
        have_nxt = 2'd0;
      end else begin
        if (have_r == 2'd1) cont0_nxt = data_byte;
        else                cont1_nxt = data_byte;
        have_nxt = have_r + 2'd1;
      end
    end else begin
      // broken sequence: dump it raw, then retry this byte as a lead
      job.flush_n = have_r;
      have_nxt    = 2'd0;
      do_lead     = 1'b1;
    end

    if (do_lead) begin
      if (data_byte < 8'h80) begin
        job.fin_v  = 1'b1;
        job.fin_cp = {13'd0, data_byte};
      end else if (data_byte >= u8d_pkg::LEAD_MIN && data_byte <= u8d_pkg::LEAD_MAX) begin
        lead_nxt = data_byte;
        have_nxt = 2'd1;
      end else begin
        job.fin_v   = 1'b1;
        job.fin_cp  = {13'd0, data_byte};
        job.fin_raw = 1'b1;
      end
    end

    push = accept && ((job.flush_n != 2'd0) || job.fin_v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r  <= '0;
      cont0_r <= '0;
      cont1_r <= '0;
      have_r  <= '0;
    end else if (accept) begin
      lead_r  <= lead_nxt;
      cont0_r <= cont0_nxt;
      cont1_r <= cont1_nxt;
      have_r  <= have_nxt;
    end
  end

endmodule

/* src/u8d_queue.sv */
// small job queue between front and back
`timescale 1ns / 1ps

module u8d_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  u8d_pkg::job_t       push_job,
  input  logic                pop,
  output u8d_pkg::job_t       head_job,
  output u8d_pkg::q_stat_t    stat
);

  u8d_pkg::job_t mem [u8d_pkg::Q_DEPTH];

  logic [u8d_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [u8d_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [u8d_pkg::Q_CNT_W-1:0] count_r, count_nxt;

  assign stat.full  = count_r == u8d_pkg::Q_CNT_W'(u8d_pkg::Q_DEPTH);
  assign stat.empty = count_r == '0;
  assign head_job   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!stat.full || pop))
    else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("job popped from empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count lost a push");

endmodule

/* src/u8d_back.sv */
// back end: expands one job into result words behind an output register
`timescale 1ns / 1ps

module u8d_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  u8d_pkg::job_t              head_job,
  input  u8d_pkg::q_stat_t           stat,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [u8d_pkg::CP_W-1:0]   out_cp,
  output logic [u8d_pkg::CNT_W-1:0]  out_cnt,
  output logic                       out_raw,
  output logic                       out_last
);

  logic [1:0]                 idx_r, idx_nxt;
  logic                       valid_r, valid_nxt;
  logic [u8d_pkg::CP_W-1:0]   cp_r, cp_nxt;
  logic [u8d_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       raw_r, raw_nxt;
  logic                       last_r, last_nxt;

  logic       load;
  logic [2:0] total;
  logic       is_last;
  logic [7:0] raw_byte;

  always_comb begin
    total   = {1'b0, head_job.flush_n} + {2'b0, head_job.fin_v};
    is_last = ({1'b0, idx_r} + 3'd1) == total;
    case (idx_r)
      2'd0:    raw_byte = head_job.lead;
      2'd1:    raw_byte = head_job.cont0;
      default: raw_byte = head_job.cont1;
    endcase

    load = !stat.empty && (!valid_r || out_ready);
    pop  = load && is_last;

    valid_nxt = valid_r && !out_ready;
    cp_nxt    = cp_r;
    cnt_nxt   = cnt_r;
    raw_nxt   = raw_r;
    last_nxt  = last_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      last_nxt  = is_last;
      idx_nxt   = is_last ? 2'd0 : idx_r + 2'd1;
      if (idx_r < head_job.flush_n) begin
        cp_nxt  = {13'd0, raw_byte};
        cnt_nxt = 3'd1;
        raw_nxt = 1'b1;
      end else begin
        cp_nxt  = head_job.fin_cp;
        cnt_nxt = head_job.fin_cnt;
        raw_nxt = head_job.fin_raw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_r   <= cp_nxt;
    cnt_r  <= cnt_nxt;
    raw_r  <= raw_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_cp    = cp_r;
  assign out_cnt   = cnt_r;
  assign out_raw   = raw_r;
  assign out_last  = last_r;

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.empty |-> ({1'b0, idx_r} < total))
    else $error("result index past end of job");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (valid_r && last_r))
    else $error("job retired without a last result");

  a_idx_restart: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (idx_r == 2'd0))
    else $error("result index not restarted after job");

endmodule

/* tb/strict_utf8_decoder_checker.sv */
// result checker for the strict utf-8 decoder: byte-level prediction and word compare
`timescale 1ns / 1ps

module strict_utf8_decoder_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  output int          mismatch_count,
  output int          words_owed
);

  localparam logic [7:0] END_OF_TEXT = 8'h00;
  localparam logic [7:0] ASCII_END   = 8'h80;

  typedef struct packed {
    logic [u8d_pkg::CP_W-1:0]  code_point;
    logic [u8d_pkg::CNT_W-1:0] byte_count;
    logic                      is_raw;
    logic                      run_last;
  } scalar_word_t;

  scalar_word_t owed_q[$];

  // decoder state mirrored here
  logic [7:0] lead_r;
  logic [7:0] cont_r [2];
  logic [1:0] held_r;

  scalar_word_t burst [4];
  int           burst_n;
  int           errs = 0;

  task automatic emit(input logic [u8d_pkg::CP_W-1:0] cp,
                      input logic [u8d_pkg::CNT_W-1:0] cnt, input logic raw);
    burst[burst_n] = '{code_point: cp, byte_count: cnt, is_raw: raw, run_last: 1'b0};
    burst_n++;
  endtask

  // pending lead and continuation bytes go out raw
  task automatic flush_raw();
    if (held_r != 2'd0) begin
      emit(u8d_pkg::CP_W'(lead_r), 3'd1, 1'b1);
      for (int i = 1; i < held_r; i++) emit(u8d_pkg::CP_W'(cont_r[i-1]), 3'd1, 1'b1);
    end
    held_r = 2'd0;
  endtask

  task automatic open_seq(input logic [7:0] b);
    if (b < ASCII_END) begin
      emit(u8d_pkg::CP_W'(b), 3'd1, 1'b0);
    end else if (b >= u8d_pkg::LEAD_MIN && b <= u8d_pkg::LEAD_MAX) begin
      lead_r = b;
      held_r = 2'd1;
    end else begin
      emit(u8d_pkg::CP_W'(b), 3'd1, 1'b1);
    end
  endtask

  // second byte has tighter bounds after e0, ed, f0, f4
  function automatic logic cont_fits(input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = u8d_pkg::CONT_TAG;
    hi = u8d_pkg::CONT_MAX;
    if ((b & u8d_pkg::CONT_MASK) != u8d_pkg::CONT_TAG) return 1'b0;
    if (held_r == 2'd1) begin
      if (lead_r == u8d_pkg::LEAD_E0) lo = u8d_pkg::E0_LO;
      if (lead_r == u8d_pkg::LEAD_ED) hi = u8d_pkg::ED_HI;
      if (lead_r == u8d_pkg::LEAD_F0) lo = u8d_pkg::F0_LO;
      if (lead_r == u8d_pkg::LEAD_MAX) hi = u8d_pkg::F4_HI;
    end
    return (b >= lo) && (b <= hi);
  endfunction

  function automatic logic [2:0] seq_len(input logic [7:0] lead);
    if (lead <= u8d_pkg::LEAD2_MAX) return 3'd2;
    if (lead <= u8d_pkg::LEAD3_MAX) return 3'd3;
    return 3'd4;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    logic [2:0]               need;
    logic [u8d_pkg::CP_W-1:0] cp;
    burst_n = 0;
    if (b == END_OF_TEXT) begin
      flush_raw();
    end else if (held_r == 2'd0) begin
      open_seq(b);
    end else if (cont_fits(b)) begin
      need = seq_len(lead_r);
      if ({1'b0, held_r} + 3'd1 >= need) begin
        case (need)
          3'd2: cp = u8d_pkg::CP_W'({lead_r[4:0], b[5:0]});
          3'd3: cp = u8d_pkg::CP_W'({lead_r[3:0], cont_r[0][5:0], b[5:0]});
          default: cp = {lead_r[2:0], cont_r[0][5:0], cont_r[1][5:0], b[5:0]};
        endcase
        held_r = 2'd0;
        emit(cp, need, 1'b0);
      end else begin
        cont_r[1'(held_r - 2'd1)] = b;
        held_r = held_r + 2'd1;
      end
    end else begin
      // broken sequence: flush, then the breaking byte starts over
      flush_raw();
      open_seq(b);
    end
    for (int i = 0; i < burst_n; i++) begin
      burst[i].run_last = (i == burst_n - 1);
      owed_q.push_back(burst[i]);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %h, got %h", name, want_v, got_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin : watch
    scalar_word_t want;
    if (!rst_n) begin
      lead_r    = 8'h00;
      cont_r[0] = 8'h00;
      cont_r[1] = 8'h00;
      held_r    = 2'd0;
      owed_q.delete();
    end else begin
      if (in_tvalid && in_tready) decode_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        if (owed_q.size() == 0) begin
          $error("unexpected result word: code_point %h", out_tdata[u8d_pkg::CP_W-1:0]);
          errs++;
        end else begin
          want = owed_q.pop_front();
          check_field("code_point", 32'(want.code_point),
                      32'(out_tdata[u8d_pkg::CP_W-1:0]));
          check_field("byte_count", 32'(want.byte_count),
                      32'(out_tdata[u8d_pkg::CP_W+u8d_pkg::CNT_W-1:u8d_pkg::CP_W]));
          check_field("is_raw", 32'(want.is_raw), 32'(out_tuser));
          check_field("run_last", 32'(want.run_last), 32'(out_tlast));
        end
      end
    end
    mismatch_count <= errs;
    words_owed     <= owed_q.size();
  end

endmodule

/* tb/tb_strict_utf8_decoder_top.sv */
// testbench top for the strict utf-8 decoder: clock, reset, byte stimulus and verdict
`timescale 1ns / 1ps

module tb_strict_utf8_decoder_top;

  localparam int N_OPEN = 26;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;   // [20:0] code_point, [23:21] byte_count
  logic        out_tuser;   // [0] is_raw
  logic        out_tlast;   // run_last

  int mismatch_count;
  int words_owed;
  int bytes_sent = 0;
  int tx_idle    = 0;   // percent of cycles the byte source holds back
  int rx_idle    = 0;   // percent of cycles the result sink stalls

  // opening bytes: ascii and stray extremes, each rejection kind, the
  // largest code point, a four-word burst and end-of-text flushes
  logic [7:0] opening [N_OPEN] = '{
    8'h01, 8'h7F, 8'h80, 8'hFF,   // lowest and highest ascii, stray bytes
    8'hC2, 8'h80,                 // smallest two-byte form
    8'hE0, 8'h9F,                 // overlong three-byte, early rejection
    8'hED, 8'hA0,                 // surrogate, early rejection
    8'hF0, 8'h8F,                 // overlong four-byte, early rejection
    8'hF4, 8'h90,                 // past the last scalar value
    8'hF4, 8'h8F, 8'hBF, 8'hBF,   // the last scalar value
    8'hF1, 8'h80, 8'h80, 8'h41,   // three buffered bytes flushed, then ascii
    8'hE2, 8'h82, 8'h00,          // end of text flushes two pending bytes
    8'h00                         // end of text with nothing pending
  };

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  strict_utf8_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  strict_utf8_decoder_checker result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .words_owed     (words_owed)
  );

  // result sink: random stalls, changes only at the falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle);
  end

  // entered and left at a falling edge; tvalid stays high between
  // back-to-back words so it never gets two updates in one step
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // well-formed sequence with random content; keep > 0 cuts it to keep bytes when that is shorter
  task automatic send_utf8(input int keep);
    logic [7:0] seq [4];
    logic [7:0] lo;
    logic [7:0] hi;
    int         len;
    int         n;
    len = $urandom_range(2, 4);
    case (len)
      2: seq[0] = 8'($urandom_range(u8d_pkg::LEAD_MIN, u8d_pkg::LEAD2_MAX));
      3: seq[0] = ($urandom_range(0, 3) == 0) ?
                  (($urandom_range(0, 1) == 0) ? u8d_pkg::LEAD_E0 : u8d_pkg::LEAD_ED) :
                  8'($urandom_range(u8d_pkg::LEAD_E0, u8d_pkg::LEAD3_MAX));
      default: seq[0] = ($urandom_range(0, 3) == 0) ?
                  (($urandom_range(0, 1) == 0) ? u8d_pkg::LEAD_F0 : u8d_pkg::LEAD_MAX) :
                  8'($urandom_range(u8d_pkg::LEAD_F0, u8d_pkg::LEAD_MAX));
    endcase
    // second byte within the bounds its lead allows
    lo = u8d_pkg::CONT_TAG;
    hi = u8d_pkg::CONT_MAX;
    if (seq[0] == u8d_pkg::LEAD_E0) lo = u8d_pkg::E0_LO;
    if (seq[0] == u8d_pkg::LEAD_ED) hi = u8d_pkg::ED_HI;
    if (seq[0] == u8d_pkg::LEAD_F0) lo = u8d_pkg::F0_LO;
    if (seq[0] == u8d_pkg::LEAD_MAX) hi = u8d_pkg::F4_HI;
    seq[1] = 8'($urandom_range(lo, hi));
    seq[2] = 8'($urandom_range(u8d_pkg::CONT_TAG, u8d_pkg::CONT_MAX));
    seq[3] = 8'($urandom_range(u8d_pkg::CONT_TAG, u8d_pkg::CONT_MAX));
    n = (keep == 0 || keep > len) ? len : keep;
    for (int i = 0; i < n; i++) push_byte(seq[i]);
  endtask

  task automatic send_random_run();
    int         pick;
    logic [7:0] lead;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      push_byte(8'($urandom_range(1, 127)));
    end else if (pick < 65) begin
      send_utf8(0);
    end else if (pick < 80) begin
      // sequence, possibly truncated, followed by any byte
      send_utf8($urandom_range(1, 3));
      push_byte(8'($urandom_range(0, 255)));
    end else if (pick < 88) begin
      // boundary lead with a second byte that may fall outside its bounds
      case ($urandom_range(0, 3))
        0: lead = u8d_pkg::LEAD_E0;
        1: lead = u8d_pkg::LEAD_ED;
        2: lead = u8d_pkg::LEAD_F0;
        default: lead = u8d_pkg::LEAD_MAX;
      endcase
      push_byte(lead);
      push_byte(8'($urandom_range(u8d_pkg::CONT_TAG, u8d_pkg::CONT_MAX)));
    end else if (pick < 96) begin
      push_byte(8'($urandom_range(0, 255)));
    end else begin
      // end of text after a sequence that may be cut short
      send_utf8($urandom_range(1, 3));
      push_byte(8'h00);
    end
  endtask

  // hold the source until every owed result word has come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (words_owed != 0) @(negedge clk);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // phase 1: source idles 38%, sink 52%
    tx_idle = 38;
    rx_idle = 52;
    for (int i = 0; i < N_OPEN; i++) push_byte(opening[i]);
    drain_results();
    while (bytes_sent < 160) send_random_run();
    drain_results();

    // phase 2: the other way round
    tx_idle = 52;
    rx_idle = 38;
    while (bytes_sent < 295) send_random_run();
    drain_results();

    // phase 3: full rate on both sides
    tx_idle = 0;
    rx_idle = 0;
    while (bytes_sent < 430) send_random_run();

    // let the tail drain, then wait on for stray words
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (words_owed != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* strict_utf8_decoder_top.f */
src/u8d_pkg.sv
src/u8d_front.sv
src/u8d_queue.sv
src/u8d_back.sv
src/strict_utf8_decoder_top.sv
tb/strict_utf8_decoder_checker.sv
tb/tb_strict_utf8_decoder_top.sv
